// ===== rtl/radio_frame_deframer_checksum_defines.svh =====
// Assertion macros shared by the deframer RTL files.
// Included by the modules that check their own logic; no other dependencies.
`ifndef RADIO_FRAME_DEFRAMER_CHECKSUM_DEFINES_SVH
`define RADIO_FRAME_DEFRAMER_CHECKSUM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RFDC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RFDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rfdc_pkg.sv =====
// Shared types, constants and helper functions of the frame deframer.
// No dependencies; imported by every deframer module.
`default_nettype none

package rfdc_pkg;

    localparam int MAX_FRAME   = 61;
    localparam int HDR_LEN     = 5;
    localparam int LEN_W       = 6;
    localparam int LEN_MAX     = (1 << LEN_W) - 1;
    localparam int PAYLOAD_CAP = (MAX_FRAME <= HDR_LEN) ? 0 :
                                 ((MAX_FRAME - HDR_LEN > LEN_MAX) ? LEN_MAX :
                                  (MAX_FRAME - HDR_LEN));

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic       KIND_PASS   = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_SHORT = 2'd1;
    localparam logic [1:0] ERR_CKSUM = 2'd2;

    typedef enum logic [1:0] {
        OP_PASS        = 2'd0,
        OP_STATUS      = 2'd1,
        OP_PASS_STATUS = 2'd2
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [7:0]       data;
        logic [7:0]       dest;
        logic [7:0]       sender;
        logic [7:0]       command;
        logic [LEN_W-1:0] total;
        logic [1:0]       err;
    } cmd_t;

    typedef struct packed {
        logic             kind;
        logic [7:0]       payload_byte;
        logic [7:0]       dest_addr;
        logic [7:0]       sender_addr;
        logic [7:0]       frame_command;
        logic [LEN_W-1:0] payload_len;
        logic [1:0]       error_code;
        logic             last;
    } result_t;

    function automatic result_t pass_word(input logic [7:0] b, input logic lst);
        result_t w;
        w               = '0;
        w.kind          = KIND_PASS;
        w.payload_byte  = b;
        w.last          = lst;
        return w;
    endfunction

    function automatic result_t status_word(input cmd_t c);
        result_t w;
        w               = '0;
        w.kind          = KIND_STATUS;
        w.dest_addr     = c.dest;
        w.sender_addr   = c.sender;
        w.frame_command = c.command;
        w.payload_len   = c.total;
        w.error_code    = c.err;
        w.last          = 1'b1;
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rfdc_front.sv =====
// Front end: parses frame words, tracks the header and checksum, and issues commands.
// Depends on rfdc_pkg and the shared assertion macro header.
`default_nettype none
`include "radio_frame_deframer_checksum_defines.svh"

module rfdc_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          frame_start,
    output      logic          q_push,
    output      rfdc_pkg::cmd_t q_data
);
    import rfdc_pkg::*;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_DEST    = 6'b000010,
        PH_SENDER  = 6'b000100,
        PH_CMD     = 6'b001000,
        PH_CKSUM   = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } phase_t;

    localparam logic [7:0] HDR_LEN8 = 8'(HDR_LEN);
    localparam logic [7:0] CAP8     = 8'(PAYLOAD_CAP);

    phase_t           phase_reg, phase_next;
    logic [7:0]       dest_reg, dest_next;
    logic [7:0]       sender_reg, sender_next;
    logic [7:0]       command_reg, command_next;
    logic [7:0]       expected_reg, expected_next;
    logic [LEN_W-1:0] total_reg, total_next;
    logic [LEN_W-1:0] left_reg, left_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       excess;
    logic [7:0]       clamped;
    logic [7:0]       sum_upd;
    logic [LEN_W-1:0] left_upd;

    always_comb
    begin
        excess   = rx_byte - HDR_LEN8;
        clamped  = (excess >= CAP8) ? CAP8 : excess;
        sum_upd  = sum_reg + rx_byte;
        left_upd = (left_reg != '0) ? left_reg - LEN_W'(1) : left_reg;

        phase_next    = phase_reg;
        dest_next     = dest_reg;
        sender_next   = sender_reg;
        command_next  = command_reg;
        expected_next = expected_reg;
        total_next    = total_reg;
        left_next     = left_reg;
        sum_next      = sum_reg;

        q_push         = 1'b0;
        q_data         = '0;
        q_data.op      = OP_PASS;
        q_data.data    = rx_byte;
        q_data.dest    = dest_reg;
        q_data.sender  = sender_reg;
        q_data.command = command_reg;
        q_data.total   = total_reg;
        q_data.err     = ERR_OK;

        if (accept)
        begin
            if (frame_start)
            begin
                total_next = (rx_byte > HDR_LEN8) ? clamped[LEN_W-1:0] : '0;
                left_next  = (rx_byte > HDR_LEN8) ? clamped[LEN_W-1:0] : '0;
                sum_next   = '0;
                phase_next = PH_DEST;
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        phase_next = PH_IDLE;
                    end
                    PH_DEST:
                    begin
                        dest_next  = rx_byte;
                        phase_next = PH_SENDER;
                    end
                    PH_SENDER:
                    begin
                        sender_next = rx_byte;
                        phase_next  = PH_CMD;
                    end
                    PH_CMD:
                    begin
                        command_next = rx_byte;
                        phase_next   = PH_CKSUM;
                    end
                    PH_CKSUM:
                    begin
                        expected_next = rx_byte;
                        if (total_reg == '0)
                        begin
                            q_push     = 1'b1;
                            q_data.op  = OP_STATUS;
                            q_data.err = ERR_SHORT;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        sum_next  = sum_upd;
                        left_next = left_upd;
                        q_push    = 1'b1;
                        if (left_upd != '0)
                        begin
                            q_data.op = OP_PASS;
                        end
                        else
                        begin
                            q_data.op  = OP_PASS_STATUS;
                            q_data.err = (sum_upd == expected_reg) ? ERR_OK : ERR_CKSUM;
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            dest_reg     <= '0;
            sender_reg   <= '0;
            command_reg  <= '0;
            expected_reg <= '0;
            total_reg    <= '0;
            left_reg     <= '0;
            sum_reg      <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            dest_reg     <= dest_next;
            sender_reg   <= sender_next;
            command_reg  <= command_next;
            expected_reg <= expected_next;
            total_reg    <= total_next;
            left_reg     <= left_next;
            sum_reg      <= sum_next;
        end
    end

    `RFDC_ASSERT_NOW(a_payload_has_bytes, phase_reg == PH_PAYLOAD, left_reg != '0, "payload phase with no bytes left")
    `RFDC_ASSERT_NOW(a_status_from_last, q_push && q_data.op == OP_PASS_STATUS, phase_reg == PH_PAYLOAD && left_reg == LEN_W'(1), "status issued before the last payload word")

endmodule

`default_nettype wire

// ===== rtl/rfdc_queue.sv =====
// Short command queue between the parser and the result generator.
// Depends on rfdc_pkg and the shared assertion macro header.
`default_nettype none
`include "radio_frame_deframer_checksum_defines.svh"

module rfdc_queue
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire rfdc_pkg::cmd_t wr_data,
    output      logic           full,
    input  wire logic           pop,
    output      rfdc_pkg::cmd_t rd_data,
    output      logic           empty
);
    import rfdc_pkg::*;

    localparam logic [QUEUE_AW-1:0] LAST_IDX = QUEUE_AW'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_AW:0]   DEPTH_C  = (QUEUE_AW + 1)'(QUEUE_DEPTH);

    cmd_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    always_comb
    begin
        full    = (count_reg == DEPTH_C);
        empty   = (count_reg == '0);
        rd_data = mem_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + QUEUE_AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + QUEUE_AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + (QUEUE_AW + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QUEUE_AW + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `RFDC_ASSERT_NOW(a_no_overflow, push, !full || pop, "command queue written while full")
    `RFDC_ASSERT_NOW(a_no_underflow, pop, !empty, "command queue read while empty")

endmodule

`default_nettype wire

// ===== rtl/rfdc_back.sv =====
// Back end: expands queued commands into result words held in an output register.
// Depends on rfdc_pkg and the shared assertion macro header.
`default_nettype none
`include "radio_frame_deframer_checksum_defines.svh"

module rfdc_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rfdc_pkg::cmd_t    q_data,
    input  wire logic              q_empty,
    output      logic              q_pop,
    input  wire logic              pop,
    output      logic              empty,
    output      rfdc_pkg::result_t word
);
    import rfdc_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    pend_reg, pend_next;
    result_t out_word_reg, out_word_next;
    cmd_t    hold_reg, hold_next;
    logic    load;

    always_comb
    begin
        load           = !out_valid_reg || pop;
        q_pop          = 1'b0;
        out_valid_next = out_valid_reg;
        pend_next      = pend_reg;
        out_word_next  = out_word_reg;
        hold_next      = hold_reg;

        if (load)
        begin
            if (pend_reg)
            begin
                out_word_next  = status_word(hold_reg);
                out_valid_next = 1'b1;
                pend_next      = 1'b0;
            end
            else if (!q_empty)
            begin
                q_pop          = 1'b1;
                out_valid_next = 1'b1;
                unique case (q_data.op)
                    OP_PASS:
                    begin
                        out_word_next = pass_word(q_data.data, 1'b1);
                    end
                    OP_STATUS:
                    begin
                        out_word_next = status_word(q_data);
                    end
                    OP_PASS_STATUS:
                    begin
                        out_word_next = pass_word(q_data.data, 1'b0);
                        hold_next     = q_data;
                        pend_next     = 1'b1;
                    end
                    default:
                    begin
                        out_valid_next = 1'b0;
                    end
                endcase
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        hold_reg     <= hold_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    assign empty = !out_valid_reg;
    assign word  = out_word_reg;

    `RFDC_ASSERT_NOW(a_pend_behind_word, pend_reg, out_valid_reg && !out_word_reg.last, "pending status without its payload word")
    `RFDC_ASSERT_NEXT(a_status_follows, out_valid_reg && pop && out_word_reg.kind == KIND_PASS && !out_word_reg.last, out_valid_reg && out_word_reg.kind == KIND_STATUS && out_word_reg.last, "status word did not follow the last payload word")

endmodule

`default_nettype wire

// ===== rtl/radio_frame_deframer_checksum.sv =====
// Path: a result word is written into the command queue and then into the output register of the result stage.
// Throughput: one byte per cycle while full is low; the last payload byte of a frame yields two words,
// which the result stage delivers one after the other from a four-entry command queue.
// Reset: rst_n clears the parser, the command queue and the result stage asynchronously;
// the parser then waits for a frame start and the result side reads empty.
// Top level: instantiates rfdc_front, rfdc_queue and rfdc_back; uses rfdc_pkg.
`default_nettype none

module radio_frame_deframer_checksum
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    output      logic                       full,
    input  wire logic [7:0]                 rx_byte,
    input  wire logic                       frame_start,
    output      logic                       empty,
    input  wire logic                       pop,
    output      logic                       kind,
    output      logic [7:0]                 payload_byte,
    output      logic [7:0]                 dest_addr,
    output      logic [7:0]                 sender_addr,
    output      logic [7:0]                 frame_command,
    output      logic [rfdc_pkg::LEN_W-1:0] payload_len,
    output      logic [1:0]                 error_code,
    output      logic                       last
);
    import rfdc_pkg::*;

    logic    accept;
    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;
    cmd_t    q_wr;
    cmd_t    q_rd;
    result_t word;

    assign full   = q_full;
    assign accept = push && !q_full;

    rfdc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .q_push      (q_push),
        .q_data      (q_wr)
    );

    rfdc_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd),
        .empty   (q_empty)
    );

    rfdc_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_rd),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .word    (word)
    );

    assign kind          = word.kind;
    assign payload_byte  = word.payload_byte;
    assign dest_addr     = word.dest_addr;
    assign sender_addr   = word.sender_addr;
    assign frame_command = word.frame_command;
    assign payload_len   = word.payload_len;
    assign error_code    = word.error_code;
    assign last          = word.last;

endmodule

`default_nettype wire

// ===== tb/tb_radio_frame_deframer_checksum.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for radio_frame_deframer_checksum, using rfdc_pkg for types and limits.
// A scoreboard class predicts the passthrough and status words of each accepted byte and
// compares every popped word with the oldest prediction; tasks drive frames with random gaps.
`default_nettype none

module tb_radio_frame_deframer_checksum;
    import rfdc_pkg::*;

    localparam int ITEMS = 600;

    typedef enum logic [2:0] {
        AWAIT_START,
        AWAIT_DEST,
        AWAIT_SENDER,
        AWAIT_CMD,
        AWAIT_CKSUM,
        IN_PAYLOAD
    } parse_state_t;

    class frame_checker;
        parse_state_t     state;
        logic [7:0]       dest;
        logic [7:0]       sender;
        logic [7:0]       command;
        logic [7:0]       cksum;
        logic [7:0]       sum;
        logic [LEN_W-1:0] total;
        logic [LEN_W-1:0] left;
        result_t          waiting[$];
        int               errors;
        int               used;

        function new();
            state   = AWAIT_START;
            dest    = '0;
            sender  = '0;
            command = '0;
            cksum   = '0;
            sum     = '0;
            total   = '0;
            left    = '0;
            errors  = 0;
            used    = 0;
        endfunction

        function result_t frame_status(logic [1:0] code);
            result_t w;
            w               = '0;
            w.kind          = KIND_STATUS;
            w.dest_addr     = dest;
            w.sender_addr   = sender;
            w.frame_command = command;
            w.payload_len   = total;
            w.error_code    = code;
            w.last          = 1'b1;
            return w;
        endfunction

        function void take_byte(logic [7:0] b, logic s);
            result_t w;
            int      n;
            used++;
            if (s) begin
                n = (b > HDR_LEN) ? b - HDR_LEN : 0;
                if (n > PAYLOAD_CAP)
                    n = PAYLOAD_CAP;
                total = LEN_W'(n);
                left  = LEN_W'(n);
                sum   = '0;
                state = AWAIT_DEST;
                return;
            end
            case (state)
                AWAIT_DEST:
                begin
                    dest  = b;
                    state = AWAIT_SENDER;
                end
                AWAIT_SENDER:
                begin
                    sender = b;
                    state  = AWAIT_CMD;
                end
                AWAIT_CMD:
                begin
                    command = b;
                    state   = AWAIT_CKSUM;
                end
                AWAIT_CKSUM:
                begin
                    cksum = b;
                    if (total == 0)
                    begin
                        state = AWAIT_START;
                        waiting.push_back(frame_status(ERR_SHORT));
                    end
                    else
                        state = IN_PAYLOAD;
                end
                IN_PAYLOAD:
                begin
                    sum = sum + b;
                    if (left != 0)
                        left = left - 1'b1;
                    w              = '0;
                    w.kind         = KIND_PASS;
                    w.payload_byte = b;
                    w.last         = (left != 0);
                    waiting.push_back(w);
                    if (left == 0)
                    begin
                        state = AWAIT_START;
                        waiting.push_back(frame_status((sum == cksum) ? ERR_OK : ERR_CKSUM));
                    end
                end
                default:
                    ;
            endcase
        endfunction

        function void compare_field(string name, int e, int a);
            if (e != a)
            begin
                errors++;
                $display("%0t: %s expected %0h, actual %0h", $time, name, e, a);
            end
        endfunction

        function void check_word(result_t got);
            result_t e;
            if (waiting.size() == 0)
            begin
                errors++;
                $display("%0t: word expected none, actual %h", $time, got);
                return;
            end
            e = waiting.pop_front();
            compare_field("kind", e.kind, got.kind);
            compare_field("payload_byte", e.payload_byte, got.payload_byte);
            compare_field("dest_addr", e.dest_addr, got.dest_addr);
            compare_field("sender_addr", e.sender_addr, got.sender_addr);
            compare_field("frame_command", e.frame_command, got.frame_command);
            compare_field("payload_len", e.payload_len, got.payload_len);
            compare_field("error_code", e.error_code, got.error_code);
            compare_field("last", e.last, got.last);
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             push;
    logic             full;
    logic [7:0]       rx_byte;
    logic             frame_start;
    logic             empty;
    logic             pop;
    logic             kind;
    logic [7:0]       payload_byte;
    logic [7:0]       dest_addr;
    logic [7:0]       sender_addr;
    logic [7:0]       frame_command;
    logic [LEN_W-1:0] payload_len;
    logic [1:0]       error_code;
    logic             last;

    frame_checker     sb;
    bit               quiet;

    radio_frame_deframer_checksum dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .rx_byte       (rx_byte),
        .frame_start   (frame_start),
        .empty         (empty),
        .pop           (pop),
        .kind          (kind),
        .payload_byte  (payload_byte),
        .dest_addr     (dest_addr),
        .sender_addr   (sender_addr),
        .frame_command (frame_command),
        .payload_len   (payload_len),
        .error_code    (error_code),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    initial
    begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n)
        begin
            if (push && !full)
                sb.take_byte(rx_byte, frame_start);
            if (pop && !empty)
            begin
                got.kind          = kind;
                got.payload_byte  = payload_byte;
                got.dest_addr     = dest_addr;
                got.sender_addr   = sender_addr;
                got.frame_command = frame_command;
                got.payload_len   = payload_len;
                got.error_code    = error_code;
                got.last          = last;
                sb.check_word(got);
            end
        end
    end

    // The receiver stalls in bursts until the last part of the run.
    initial
    begin
        int hold;
        hold = 0;
        pop  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                pop  = 1'b0;
                hold = hold - 1;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                pop  = 1'b0;
                hold = $urandom_range(1, 14) - 1;
            end
            else
                pop = 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic put_byte(input logic [7:0] b, input logic s);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            push = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        push        = 1'b1;
        rx_byte     = b;
        frame_start = s;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic put_header(input logic [7:0] d, input logic [7:0] s, input logic [7:0] c,
                              input logic [7:0] k);
        put_byte(d, 1'b0);
        put_byte(s, 1'b0);
        put_byte(c, 1'b0);
        put_byte(k, 1'b0);
    endtask

    task automatic send_frame(input int len);
        logic [7:0] body[$];
        logic [7:0] sum;
        logic [7:0] ck;
        int         n;
        int         taken;
        int         cut;
        n     = (len > HDR_LEN) ? len - HDR_LEN : 0;
        taken = (n > PAYLOAD_CAP) ? PAYLOAD_CAP : n;
        sum   = '0;
        for (int i = 0; i < n; i++)
        begin
            body.push_back(8'($urandom_range(0, 255)));
            if (i < taken)
                sum = sum + body[i];
        end
        ck  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : sum;
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4 + n) : 5 + n;
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)), 1'b0);
        put_byte(8'(len), 1'b1);
        if (cut > 0) put_byte(8'($urandom_range(0, 255)), 1'b0);
        if (cut > 1) put_byte(8'($urandom_range(0, 255)), 1'b0);
        if (cut > 2) put_byte(8'($urandom_range(0, 255)), 1'b0);
        if (cut > 3) put_byte(ck, 1'b0);
        for (int i = 0; i < n && i + 4 < cut; i++)
            put_byte(body[i], 1'b0);
    endtask

    initial
    begin
        bit paused;
        int r;
        sb          = new();
        quiet       = 1'b0;
        paused      = 1'b0;
        rst_n       = 1'b0;
        push        = 1'b0;
        rx_byte     = '0;
        frame_start = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h00, 1'b1);
        put_header(8'hFF, 8'h00, 8'hA5, 8'h5A);
        put_byte(8'h05, 1'b1);
        put_header(8'h12, 8'h34, 8'h56, 8'h78);
        put_byte(8'h06, 1'b1);
        put_header(8'h00, 8'hFF, 8'h00, 8'hFF);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h07, 1'b1);
        put_header(8'hC3, 8'h3C, 8'h01, 8'h00);
        put_byte(8'h80, 1'b0);
        put_byte(8'h81, 1'b0);
        put_byte(8'h0A, 1'b1);
        put_byte(8'h11, 1'b0);
        put_byte(8'h06, 1'b1);
        put_header(8'h22, 8'h33, 8'h44, 8'h10);
        put_byte(8'h10, 1'b0);

        send_frame(MAX_FRAME);
        send_frame(255);
        while (sb.used < ITEMS)
        begin
            if (sb.used >= ITEMS * 9 / 10)
                quiet = 1'b1;
            if (!paused && sb.used >= ITEMS / 2)
            begin
                paused = 1'b1;
                push   = 1'b0;
                while (sb.waiting.size() != 0)
                    @(negedge clk);
            end
            r = $urandom_range(0, 99);
            if (r < 8)
                send_frame($urandom_range(0, HDR_LEN));
            else if (r < 12)
                send_frame($urandom_range(PAYLOAD_CAP, 255));
            else
                send_frame($urandom_range(HDR_LEN + 1, 20));
        end
        push = 1'b0;

        while (sb.waiting.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.waiting.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/rfdc_pkg.sv
rtl/rfdc_front.sv
rtl/rfdc_queue.sv
rtl/rfdc_back.sv
rtl/radio_frame_deframer_checksum.sv
tb/tb_radio_frame_deframer_checksum.sv
